[sv/egsd_pkg.sv]
// ----------------------------------------------------------------------------
// egsd_pkg
// shared types, constants and helpers of the edge and grid seed detector
// ----------------------------------------------------------------------------
package egsd_pkg;

    // default geometry limits
    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;

    // register indexes of the configuration port
    localparam logic [1:0] REG_IMAGE_WIDTH    = 2'd0;
    localparam logic [1:0] REG_EDGE_THRESHOLD = 2'd1;
    localparam logic [1:0] REG_GRID_SPACING   = 2'd2;

    // register reset values
    localparam logic [11:0] RST_IMAGE_WIDTH    = 12'd640;
    localparam logic [7:0]  RST_EDGE_THRESHOLD = 8'd55;
    localparam logic [7:0]  RST_GRID_SPACING   = 8'd12;

    // field widths
    localparam int PIX_W   = 24;
    localparam int COORD_W = 11;
    localparam int INDEX_W = 22;
    localparam int CMP_W   = 14;  // wide enough for any width or height limit plus one

    localparam logic [INDEX_W-1:0] INDEX_MAX = {INDEX_W{1'b1}};

    // per-pixel control carried from the scan stage into the window stage
    typedef struct packed {
        logic interior;  // centre is not on a border
        logic on_grid;   // centre lies on both grid lines
        logic first;     // pixel opened a frame
        logic fwd;       // line buffer word comes from the previous write
    } ctl_t;

    // all three channel differences strictly above the threshold
    function automatic logic is_edge(input logic [PIX_W-1:0] c, input logic [PIX_W-1:0] n,
                                     input logic [7:0] th);
        logic       hit;
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] d;
        hit = 1'b1;
        for (int k = 0; k < 3; k++) begin
            a = c[8*k +: 8];
            b = n[8*k +: 8];
            d = (a > b) ? (a - b) : (b - a);
            if (d <= th) begin
                hit = 1'b0;
            end
        end
        return hit;
    endfunction

endpackage

[sv/egsd_ram.sv]
// ----------------------------------------------------------------------------
// egsd_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module egsd_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 2048,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/egsd_scan.sv]
// ----------------------------------------------------------------------------
// egsd_scan
// raster position and grid phase counters, line buffer read address,
// stage register feeding the window stage
// ----------------------------------------------------------------------------
module egsd_scan #(
    parameter int MAX_WIDTH  = egsd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = egsd_pkg::DEF_MAX_HEIGHT,
    localparam int CW        = $clog2(MAX_WIDTH),
    localparam int RW        = $clog2(MAX_HEIGHT)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  logic                         frame_start,
    input  logic [egsd_pkg::PIX_W-1:0]   pix,
    input  logic [11:0]                  image_width,
    input  logic [7:0]                   grid_spacing,
    input  logic                         fire,
    output logic [CW-1:0]                rd_col,
    output logic                         s1_valid,
    output logic [CW-1:0]                s1_col,
    output logic [RW-1:0]                s1_row,
    output logic [egsd_pkg::PIX_W-1:0]   s1_pix,
    output egsd_pkg::ctl_t               s1_ctl
);

    localparam int XW = egsd_pkg::CMP_W;

    logic [CW-1:0] col_reg, col_next, cur_col;
    logic [RW-1:0] row_reg, row_next, cur_row;
    logic [7:0]    cph_reg, cph_next, cur_cph;
    logic [7:0]    rph_reg, rph_next, cur_rph;
    logic [XW-1:0] eff_w;
    logic          grid_any;
    egsd_pkg::ctl_t ctl_next;

    logic                       s1_valid_reg, s1_valid_next;
    logic [CW-1:0]              s1_col_reg;
    logic [RW-1:0]              s1_row_reg;
    logic [egsd_pkg::PIX_W-1:0] s1_pix_reg;
    egsd_pkg::ctl_t             s1_ctl_reg;

    function automatic logic [7:0] phase_step(input logic [7:0] p, input logic [7:0] sp);
        logic [8:0] q;
        q = {1'b0, p} + 9'd1;
        return (q >= {1'b0, sp}) ? 8'd0 : q[7:0];
    endfunction

    always_comb
    begin
        cur_col = frame_start ? '0 : col_reg;
        cur_row = frame_start ? '0 : row_reg;
        cur_cph = frame_start ? '0 : cph_reg;
        cur_rph = frame_start ? '0 : rph_reg;

        eff_w = (XW'(image_width) < XW'(MAX_WIDTH)) ? XW'(image_width) : XW'(MAX_WIDTH);
        grid_any = (grid_spacing <= 8'd1);

        ctl_next.interior = (cur_col >= CW'(2)) && (XW'(cur_col) < eff_w)
                            && (cur_row >= RW'(2));
        ctl_next.on_grid  = grid_any || ((cur_cph == 8'd1) && (cur_rph == 8'd1));
        ctl_next.first    = frame_start;
        ctl_next.fwd      = fire && s1_valid_reg && (s1_col_reg == cur_col);

        if ((XW'(cur_col) + XW'(1)) >= eff_w)
        begin
            col_next = '0;
            cph_next = '0;
            if ((XW'(cur_row) + XW'(1)) >= XW'(MAX_HEIGHT))
            begin
                row_next = '0;
                rph_next = '0;
            end
            else
            begin
                row_next = cur_row + RW'(1);
                rph_next = phase_step(cur_rph, grid_spacing);
            end
        end
        else
        begin
            col_next = cur_col + CW'(1);
            cph_next = phase_step(cur_cph, grid_spacing);
            row_next = cur_row;
            rph_next = cur_rph;
        end

        s1_valid_next = accept ? 1'b1 : (fire ? 1'b0 : s1_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            cph_reg      <= '0;
            rph_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s1_ctl_reg   <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (accept)
            begin
                col_reg    <= col_next;
                row_reg    <= row_next;
                cph_reg    <= cph_next;
                rph_reg    <= rph_next;
                s1_ctl_reg <= ctl_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg <= cur_col;
            s1_row_reg <= cur_row;
            s1_pix_reg <= pix;
        end
    end

    assign rd_col   = cur_col;
    assign s1_valid = s1_valid_reg;
    assign s1_col   = s1_col_reg;
    assign s1_row   = s1_row_reg;
    assign s1_pix   = s1_pix_reg;
    assign s1_ctl   = s1_ctl_reg;

endmodule

[sv/egsd_window.sv]
// ----------------------------------------------------------------------------
// egsd_window
// 3x3 window, neighbor difference test, seed numbering and output register
// ----------------------------------------------------------------------------
module egsd_window #(
    parameter int MAX_WIDTH  = egsd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = egsd_pkg::DEF_MAX_HEIGHT,
    localparam int CW        = $clog2(MAX_WIDTH),
    localparam int RW        = $clog2(MAX_HEIGHT),
    localparam int PW        = egsd_pkg::PIX_W
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s1_valid,
    input  logic [CW-1:0]     s1_col,
    input  logic [RW-1:0]     s1_row,
    input  logic [PW-1:0]     s1_pix,
    input  egsd_pkg::ctl_t    s1_ctl,
    input  logic [2*PW-1:0]   rdata,
    input  logic [7:0]        edge_threshold,
    input  logic              m_tready,
    output logic              fire,
    output logic              wr_en,
    output logic [2*PW-1:0]   wr_data,
    output logic              m_tvalid,
    output logic [71:0]       m_tdata,
    output logic              m_tuser
);

    localparam int IW = egsd_pkg::INDEX_W;

    // columns 1 and 2 of the window, rows top, middle, bottom
    logic [PW-1:0]   c1_reg [3];
    logic [PW-1:0]   c2_reg [3];
    logic [2*PW-1:0] fwd_data_reg;
    logic [IW-1:0]   cnt_reg;
    logic            out_valid_reg;
    logic [71:0]     out_data_reg;
    logic            out_edge_reg;

    logic [2*PW-1:0] eff;
    logic [PW-1:0]   new_col [3];
    logic [PW-1:0]   centre;
    logic            edge_hit;
    logic            seed;
    logic            out_free;
    logic [IW-1:0]   base;
    logic [IW-1:0]   cnt_next;
    logic [egsd_pkg::COORD_W-1:0] sx;
    logic [egsd_pkg::COORD_W-1:0] sy;

    always_comb
    begin
        eff        = s1_ctl.fwd ? fwd_data_reg : rdata;
        new_col[0] = eff[PW-1:0];
        new_col[1] = eff[2*PW-1:PW];
        new_col[2] = s1_pix;
        centre     = c2_reg[1];

        edge_hit = egsd_pkg::is_edge(centre, c1_reg[0], edge_threshold)
                 | egsd_pkg::is_edge(centre, c1_reg[1], edge_threshold)
                 | egsd_pkg::is_edge(centre, c1_reg[2], edge_threshold)
                 | egsd_pkg::is_edge(centre, c2_reg[0], edge_threshold)
                 | egsd_pkg::is_edge(centre, c2_reg[2], edge_threshold)
                 | egsd_pkg::is_edge(centre, new_col[0], edge_threshold)
                 | egsd_pkg::is_edge(centre, new_col[1], edge_threshold)
                 | egsd_pkg::is_edge(centre, new_col[2], edge_threshold);

        seed     = s1_ctl.interior && (edge_hit || s1_ctl.on_grid);
        out_free = !out_valid_reg || m_tready;
        fire     = s1_valid && (!seed || out_free);

        base = s1_ctl.first ? '0 : cnt_reg;
        if (seed && (base < egsd_pkg::INDEX_MAX))
        begin
            cnt_next = base + IW'(1);
        end
        else
        begin
            cnt_next = base;
        end

        sx = egsd_pkg::COORD_W'(s1_col - CW'(1));
        sy = egsd_pkg::COORD_W'(s1_row - RW'(1));

        // upper entry takes the old middle, middle entry takes the new pixel
        wr_en   = fire;
        wr_data = {s1_pix, new_col[1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                cnt_reg <= cnt_next;
            end
            if (fire && seed)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            for (int r = 0; r < 3; r++)
            begin
                c1_reg[r] <= c2_reg[r];
                c2_reg[r] <= new_col[r];
            end
            fwd_data_reg <= wr_data;
        end
        if (fire && seed)
        begin
            out_data_reg <= {4'b0000, base, centre[23:16], centre[15:8], centre[7:0], sy, sx};
            out_edge_reg <= edge_hit;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_edge_reg;

endmodule

[sv/edge_and_grid_seed_detector.sv]
// ----------------------------------------------------------------------------
// edge_and_grid_seed_detector
// finds edge seeds and fallback grid seeds in a raster rgb pixel stream
// ----------------------------------------------------------------------------
//
// channel   | dir | transaction               | payload
// ----------+-----+---------------------------+---------------------------------
// s_axis    | in  | one pixel                 | tdata rgb, tuser frame start
// m_axis    | out | one seed                  | tdata coords, color, index;
//           |     |                           | tuser found by edge
// cfg       | in  | one register write        | cfg_index, cfg_data
//
// one pixel per clock while no seed waits on a stalled output; a seed's window
// completes one row and one pixel after the seed pixel, and the seed then passes
// the line buffer read and stage register, then the window test into the output register
// the line buffers share one 48-bit ram, read at pixel accept and written
// back when that pixel leaves the window stage; a same-column read right behind a write is forwarded
// reset clears counters and handshakes and loads the register reset values, the ram gets no clearing pass
// a stalled output holds its seed; pixels that make no seed keep flowing,
// the next seed waits in the window stage and holds the input
//
module edge_and_grid_seed_detector #(
    parameter int MAX_WIDTH  = egsd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = egsd_pkg::DEF_MAX_HEIGHT
) (
    input  logic        clk,
    input  logic        rst_n,
    // pixel input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // pixel_red, pixel_green, pixel_blue
    input  logic        s_axis_tuser,   // frame_start
    // seed output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // seed_x, seed_y, seed_red, seed_green,
                                        // seed_blue, seed_index, zero pad
    output logic        m_axis_tuser,   // found_by_edge
    // configuration writes
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int PW = egsd_pkg::PIX_W;

    // configuration registers
    logic [11:0] image_width_reg;
    logic [7:0]  edge_threshold_reg;
    logic [7:0]  grid_spacing_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg    <= egsd_pkg::RST_IMAGE_WIDTH;
            edge_threshold_reg <= egsd_pkg::RST_EDGE_THRESHOLD;
            grid_spacing_reg   <= egsd_pkg::RST_GRID_SPACING;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                egsd_pkg::REG_IMAGE_WIDTH:    image_width_reg    <= cfg_data;
                egsd_pkg::REG_EDGE_THRESHOLD: edge_threshold_reg <= cfg_data[7:0];
                egsd_pkg::REG_GRID_SPACING:   grid_spacing_reg   <= cfg_data[7:0];
                default:                      ;  // writes beyond the list are dropped
            endcase
        end
    end

    // stage handshake: the scan stage is refilled whenever it empties or fires
    logic                accept;
    logic                fire;
    logic [CW-1:0]       rd_col;
    logic                s1_valid;
    logic [CW-1:0]       s1_col;
    logic [RW-1:0]       s1_row;
    logic [PW-1:0]       s1_pix;
    egsd_pkg::ctl_t      s1_ctl;
    logic [2*PW-1:0]     rdata;
    logic                wr_en;
    logic [2*PW-1:0]     wr_data;

    assign s_axis_tready = !s1_valid || fire;
    assign accept        = s_axis_tvalid && s_axis_tready;

    egsd_scan #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .frame_start  (s_axis_tuser),
        .pix          (s_axis_tdata),
        .image_width  (image_width_reg),
        .grid_spacing (grid_spacing_reg),
        .fire         (fire),
        .rd_col       (rd_col),
        .s1_valid     (s1_valid),
        .s1_col       (s1_col),
        .s1_row       (s1_row),
        .s1_pix       (s1_pix),
        .s1_ctl       (s1_ctl)
    );

    // line buffers: low half upper row, high half middle row
    egsd_ram #(
        .WIDTH (2*PW),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (s1_col),
        .wdata (wr_data),
        .re    (accept),
        .raddr (rd_col),
        .rdata (rdata)
    );

    egsd_window #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_window (
        .clk            (clk),
        .rst_n          (rst_n),
        .s1_valid       (s1_valid),
        .s1_col         (s1_col),
        .s1_row         (s1_row),
        .s1_pix         (s1_pix),
        .s1_ctl         (s1_ctl),
        .rdata          (rdata),
        .edge_threshold (edge_threshold_reg),
        .m_tready       (m_axis_tready),
        .fire           (fire),
        .wr_en          (wr_en),
        .wr_data        (wr_data),
        .m_tvalid       (m_axis_tvalid),
        .m_tdata        (m_axis_tdata),
        .m_tuser        (m_axis_tuser)
    );

endmodule
